FILE: hw/rtl/wtv_pkg.sv
package wtv_pkg;

   // Chain length limit and the address widths that follow from it.
   localparam int MAX_NODES = 64;
   localparam int NODE_AW   = $clog2(MAX_NODES);
   localparam int SEG_DEPTH = 1024;
   localparam int SEG_AW    = $clog2(SEG_DEPTH);

   typedef logic signed [47:0] q_type;
   typedef logic signed [49:0] q_wide_type;

   localparam q_type Q_MAX = {1'b0, {47{1'b1}}};
   localparam q_type Q_MIN = {1'b1, 47'd0};

   typedef enum logic {
      ARITH_DIV = 1'b0,
      ARITH_MUL = 1'b1
   } arith_op_type;

   typedef struct packed {
      logic         start;
      arith_op_type op;
      q_type        a;
      q_type        b;
   } arith_cmd_type;

   typedef struct packed {
      logic  done;
      q_type result;
   } arith_rsp_type;

   function automatic q_wide_type ext50(input q_type a);
      ext50 = {{2{a[47]}}, a};
   endfunction

   function automatic q_type sat_q(input q_wide_type v);
      if (v > ext50(Q_MAX)) begin
         sat_q = Q_MAX;
      end else if (v < ext50(Q_MIN)) begin
         sat_q = Q_MIN;
      end else begin
         sat_q = v[47:0];
      end
   endfunction

   function automatic q_type add_q(input q_type a, input q_type b);
      add_q = sat_q(ext50(a) + ext50(b));
   endfunction

   function automatic q_type neg_q(input q_type a);
      neg_q = sat_q(-ext50(a));
   endfunction

   function automatic logic signed [31:0] sat32(input q_type a);
      if (a > 48'sh0000_7FFF_FFFF) begin
         sat32 = 32'sh7FFF_FFFF;
      end else if (a < -48'sh0000_8000_0000) begin
         sat32 = -32'sh8000_0000;
      end else begin
         sat32 = a[31:0];
      end
   endfunction

endpackage

FILE: hw/rtl/wtv_arith.sv
module wtv_arith (
   input  logic                   clock,
   input  logic                   reset,
   input  wtv_pkg::arith_cmd_type cmd,
   output wtv_pkg::arith_rsp_type rsp
);
   import wtv_pkg::*;

   // Shared sequential unit: restoring division one quotient bit per cycle,
   // or shift-add multiplication one multiplier bit per cycle.
   typedef enum logic [2:0] {
      AR_IDLE = 3'b001,
      AR_RUN  = 3'b010,
      AR_FIN  = 3'b100
   } ar_state_type;

   ar_state_type ar_state_ff, ar_state_in;
   arith_op_type op_ff, op_in;
   logic         neg_ff, neg_in;
   logic [6:0]   cnt_ff, cnt_in;
   logic [47:0]  acc_ff, acc_in;
   logic [63:0]  sh_ff, sh_in;
   logic [47:0]  opnd_ff, opnd_in;
   q_type        result_ff, result_in;
   logic         done_ff, done_in;

   logic [47:0] a_mag, b_mag;
   logic [48:0] rem_sh, mac;
   logic [79:0] mag80;
   logic [79:0] lim;
   q_type       fin_val;

   always_comb begin
      a_mag  = cmd.a[47] ? 48'(-cmd.a) : 48'(cmd.a);
      b_mag  = cmd.b[47] ? 48'(-cmd.b) : 48'(cmd.b);
      rem_sh = {acc_ff, sh_ff[63]};
      mac    = {1'b0, acc_ff} + (sh_ff[0] ? {1'b0, opnd_ff} : 49'd0);
      mag80  = (op_ff == ARITH_DIV) ? {16'd0, sh_ff} : {acc_ff, sh_ff[47:16]};
      lim    = {32'd0, 1'b1, 47'd0};
      if (neg_ff) begin
         fin_val = (mag80 > lim) ? Q_MIN : q_type'(48'd0 - mag80[47:0]);
      end else begin
         fin_val = (mag80 >= lim) ? Q_MAX : q_type'(mag80[47:0]);
      end
   end

   always_comb begin
      ar_state_in = ar_state_ff;
      op_in       = op_ff;
      neg_in      = neg_ff;
      cnt_in      = cnt_ff;
      acc_in      = acc_ff;
      sh_in       = sh_ff;
      opnd_in     = opnd_ff;
      result_in   = result_ff;
      done_in     = 1'b0;
      case (ar_state_ff)
         AR_IDLE: begin
            if (cmd.start) begin
               op_in  = cmd.op;
               neg_in = cmd.a[47] ^ cmd.b[47];
               acc_in = '0;
               if (cmd.op == ARITH_DIV) begin
                  opnd_in = b_mag;
                  sh_in   = {a_mag, 16'd0};
                  cnt_in  = 7'd63;
                  if (b_mag == 48'd0) begin
                     // Zero divisor: the sign of the numerator picks the result.
                     done_in = 1'b1;
                     if (cmd.a > 48'sd0) begin
                        result_in = Q_MAX;
                     end else if (cmd.a < 48'sd0) begin
                        result_in = Q_MIN;
                     end else begin
                        result_in = '0;
                     end
                  end else begin
                     ar_state_in = AR_RUN;
                  end
               end else begin
                  opnd_in     = a_mag;
                  sh_in       = {16'd0, b_mag};
                  cnt_in      = 7'd47;
                  ar_state_in = AR_RUN;
               end
            end
         end
         AR_RUN: begin
            if (op_ff == ARITH_DIV) begin
               if (rem_sh >= {1'b0, opnd_ff}) begin
                  acc_in = 48'(rem_sh - {1'b0, opnd_ff});
                  sh_in  = {sh_ff[62:0], 1'b1};
               end else begin
                  acc_in = rem_sh[47:0];
                  sh_in  = {sh_ff[62:0], 1'b0};
               end
            end else begin
               acc_in = mac[48:1];
               sh_in  = {16'd0, mac[0], sh_ff[47:1]};
            end
            cnt_in = cnt_ff - 7'd1;
            if (cnt_ff == 7'd0) begin
               ar_state_in = AR_FIN;
            end
         end
         AR_FIN: begin
            result_in   = fin_val;
            done_in     = 1'b1;
            ar_state_in = AR_IDLE;
         end
         default: begin
            ar_state_in = AR_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ar_state_ff <= AR_IDLE;
         done_ff     <= 1'b0;
      end else begin
         ar_state_ff <= ar_state_in;
         done_ff     <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff     <= op_in;
      neg_ff    <= neg_in;
      cnt_ff    <= cnt_in;
      acc_ff    <= acc_in;
      sh_ff     <= sh_in;
      opnd_ff   <= opnd_in;
      result_ff <= result_in;
   end

   assign rsp.done   = done_ff;
   assign rsp.result = result_ff;

endmodule

FILE: hw/rtl/weighted_tv_chain_solver_unit.sv
// Channel   Direction  Ports                                               Handshake
// req       in         req_quad_weight, req_linear_term, req_edge_weight,  req_valid / req_stall
//                      req_last_node
// rsp       out        rsp_solution_value, rsp_node_position,              rsp_valid / rsp_stall
//                      rsp_final_value
//
// A node that does not end the chain is stored without stalling the input. The item that ends
// the chain starts the solve: the message is seeded, then every inner node runs breakpoint probes
// (each probe is one pass of the 64-step shared divider), the final crossing scan probes with the
// 48-step multiply, then back-tracking and the emission of result items follow. The block stalls
// its input from the last node until the last result item is taken. Reset is synchronous and
// clears the sequencer, the node counter and the result valid flag only; the stores hold no valid
// state. A stalled result item holds its value until it is taken.
module weighted_tv_chain_solver_unit (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [30:0]        req_quad_weight,
   input  logic signed [31:0] req_linear_term,
   input  logic [30:0]        req_edge_weight,
   input  logic               req_last_node,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_solution_value,
   output logic [5:0]         rsp_node_position,
   output logic               rsp_final_value
);
   import wtv_pkg::*;

   // The sequencer walks seeding, per-node clipping scans, the crossing scan,
   // back-tracking and result output. Every reads of the stores is registered,
   // so each read takes an address state and a use state.
   typedef enum logic [27:0] {
      ST_IDLE     = 28'h0000001,
      ST_INIT_RD  = 28'h0000002,
      ST_INIT     = 28'h0000004,
      ST_I_GO1    = 28'h0000008,
      ST_I_W1     = 28'h0000010,
      ST_I_GO2    = 28'h0000020,
      ST_I_W2     = 28'h0000040,
      ST_I_WR     = 28'h0000080,
      ST_K_RD     = 28'h0000100,
      ST_K_ADD    = 28'h0000200,
      ST_C_CHK    = 28'h0000400,
      ST_C_R2     = 28'h0000800,
      ST_C_R3     = 28'h0001000,
      ST_C_GO     = 28'h0002000,
      ST_C_WAIT   = 28'h0004000,
      ST_C_WR     = 28'h0008000,
      ST_F_R1     = 28'h0010000,
      ST_F_R2     = 28'h0020000,
      ST_F_R3     = 28'h0040000,
      ST_F_MGO    = 28'h0080000,
      ST_F_MWAIT  = 28'h0100000,
      ST_F_DGO    = 28'h0200000,
      ST_F_DWAIT  = 28'h0400000,
      ST_B_RD     = 28'h0800000,
      ST_B_WR     = 28'h1000000,
      ST_O_RD     = 28'h2000000,
      ST_O_LD     = 28'h4000000,
      ST_O_WAIT   = 28'h8000000
   } state_type;

   state_type state_ff, state_in;
   logic [NODE_AW-1:0] pos_ff, pos_in;
   logic [NODE_AW-1:0] last_ff, last_in;
   logic [NODE_AW-1:0] k_ff, k_in;
   logic [2:0]         wcnt_ff, wcnt_in;
   logic               up_ff, up_in;
   logic [SEG_AW-1:0]  p_ff, p_in;
   logic [SEG_AW-1:0]  l_ff, l_in;
   logic [SEG_AW-1:0]  r_ff, r_in;
   q_type              ms_ff, ms_in;
   q_type              mo_ff, mo_in;
   q_type              num_ff, num_in;
   q_type              den_ff, den_in;
   q_type              cmp_ff, cmp_in;
   q_type              pt_ff, pt_in;
   q_type              ptl_ff, ptl_in;
   logic [30:0]        lam_ff, lam_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic signed [31:0] val_ff, val_in;
   logic [5:0]         posn_ff, posn_in;
   logic               fin_ff, fin_in;

   // Stores. Node items are kept as {quad weight, linear term, edge weight}.
   logic [93:0] nd_mem [MAX_NODES];
   logic [93:0] nd_rd_ff;
   q_type       seg_mem [SEG_DEPTH];
   q_type       seg_rd_ff;
   q_type       lb_mem [MAX_NODES];
   q_type       lb_rd_ff;
   q_type       ub_mem [MAX_NODES];
   q_type       ub_rd_ff;
   q_type       sol_mem [MAX_NODES];
   q_type       sol_rd_ff;

   logic              nd_we, seg_we, lb_we, ub_we, sol_we;
   logic [SEG_AW-1:0] seg_waddr, seg_raddr;
   q_type             seg_wdata, lb_wdata, ub_wdata, sol_wdata;
   logic [NODE_AW-1:0] bnd_waddr, sol_waddr;

   arith_cmd_type arith_cmd;
   arith_rsp_type arith_rsp;

   logic [30:0]        nd_qw, nd_ew;
   logic signed [31:0] nd_lt;
   q_wide_type         nd_lt50, nd_ew50, lam50;
   q_type              off_mo, slope_ms, num_lo, num_hi, neg_ms, off_lo, off_hi;
   q_type              clamp_v, init_wdata;
   logic [SEG_AW-1:0]  seg_base, wcnt_ext;
   logic               hit;

   wtv_arith u_arith (
      .clock (clock),
      .reset (reset),
      .cmd   (arith_cmd),
      .rsp   (arith_rsp)
   );

   always_comb begin
      nd_qw    = nd_rd_ff[93:63];
      nd_lt    = nd_rd_ff[62:31];
      nd_ew    = nd_rd_ff[30:0];
      nd_lt50  = {{18{nd_lt[31]}}, nd_lt};
      nd_ew50  = {19'd0, nd_ew};
      lam50    = {19'd0, lam_ff};
      off_mo   = add_q(seg_rd_ff, mo_ff);
      slope_ms = add_q(seg_rd_ff, ms_ff);
      // Candidate clip points for the lower and the upper side.
      num_lo   = sat_q(-lam50 - ext50(off_mo));
      num_hi   = sat_q(lam50 - ext50(off_mo));
      neg_ms   = neg_q(ms_ff);
      off_lo   = sat_q(-ext50(mo_ff) - lam50);
      off_hi   = sat_q(lam50 - ext50(mo_ff));
      seg_base = {4'd0, last_ff} + {3'd0, last_ff, 1'b0} + 10'd2;
      wcnt_ext = {7'd0, wcnt_ff};
      if (pt_ff > ub_rd_ff) begin
         clamp_v = ub_rd_ff;
      end else if (pt_ff < lb_rd_ff) begin
         clamp_v = lb_rd_ff;
      end else begin
         clamp_v = pt_ff;
      end
      case (wcnt_ff)
         3'd0:    init_wdata = neg_ms;
         3'd1:    init_wdata = num_ff;
         3'd2:    init_wdata = ptl_ff;
         3'd5:    init_wdata = pt_ff;
         3'd6:    init_wdata = neg_ms;
         3'd7:    init_wdata = cmp_ff;
         default: init_wdata = '0;
      endcase
      if (up_ff) begin
         hit = arith_rsp.result > cmp_ff;
      end else begin
         // Past the last breakpoint the new lower segment is always placed.
         hit = (p_ff == r_ff + 10'd3) || (arith_rsp.result < cmp_ff);
      end
   end

   // Operand selection for the shared unit.
   always_comb begin
      arith_cmd.start = 1'b0;
      arith_cmd.op    = ARITH_DIV;
      arith_cmd.a     = num_ff;
      arith_cmd.b     = den_ff;
      case (state_ff)
         ST_I_GO1, ST_C_GO, ST_F_DGO: begin
            arith_cmd.start = 1'b1;
         end
         ST_I_GO2: begin
            arith_cmd.start = 1'b1;
            arith_cmd.a     = cmp_ff;
         end
         ST_F_MGO: begin
            arith_cmd.start = 1'b1;
            arith_cmd.op    = ARITH_MUL;
            arith_cmd.a     = den_ff;
            arith_cmd.b     = seg_rd_ff;
         end
         default: begin
            arith_cmd.start = 1'b0;
         end
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      pos_in       = pos_ff;
      last_in      = last_ff;
      k_in         = k_ff;
      wcnt_in      = wcnt_ff;
      up_in        = up_ff;
      p_in         = p_ff;
      l_in         = l_ff;
      r_in         = r_ff;
      ms_in        = ms_ff;
      mo_in        = mo_ff;
      num_in       = num_ff;
      den_in       = den_ff;
      cmp_in       = cmp_ff;
      pt_in        = pt_ff;
      ptl_in       = ptl_ff;
      lam_in       = lam_ff;
      rsp_valid_in = rsp_valid_ff;
      val_in       = val_ff;
      posn_in      = posn_ff;
      fin_in       = fin_ff;
      nd_we        = 1'b0;
      seg_we       = 1'b0;
      lb_we        = 1'b0;
      ub_we        = 1'b0;
      sol_we       = 1'b0;
      seg_waddr    = p_ff;
      seg_wdata    = pt_ff;
      seg_raddr    = p_ff;
      bnd_waddr    = k_ff;
      lb_wdata     = pt_ff;
      ub_wdata     = pt_ff;
      sol_waddr    = k_ff;
      sol_wdata    = pt_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               nd_we = 1'b1;
               // A full chain is solved even without the last-node flag.
               if (req_last_node || (pos_ff == NODE_AW'(MAX_NODES - 1))) begin
                  last_in  = pos_ff;
                  k_in     = '0;
                  state_in = ST_INIT_RD;
               end else begin
                  pos_in = pos_ff + 1'b1;
               end
            end
         end
         ST_INIT_RD: begin
            state_in = ST_INIT;
         end
         ST_INIT: begin
            ms_in  = {17'd0, nd_qw};
            mo_in  = {{16{nd_lt[31]}}, nd_lt};
            lam_in = nd_ew;
            den_in = {17'd0, nd_qw};
            if (last_ff == '0) begin
               // A single node solves directly.
               num_in   = sat_q(-nd_lt50);
               state_in = ST_F_DGO;
            end else begin
               num_in   = sat_q(-nd_ew50 - nd_lt50);
               cmp_in   = sat_q(nd_ew50 - nd_lt50);
               state_in = ST_I_GO1;
            end
         end
         ST_I_GO1: begin
            state_in = ST_I_W1;
         end
         ST_I_W1: begin
            if (arith_rsp.done) begin
               ptl_in   = arith_rsp.result;
               state_in = ST_I_GO2;
            end
         end
         ST_I_GO2: begin
            state_in = ST_I_W2;
         end
         ST_I_W2: begin
            if (arith_rsp.done) begin
               pt_in    = arith_rsp.result;
               wcnt_in  = '0;
               state_in = ST_I_WR;
            end
         end
         ST_I_WR: begin
            seg_we    = 1'b1;
            seg_waddr = seg_base + wcnt_ext;
            seg_wdata = init_wdata;
            if (wcnt_ff == 3'd0) begin
               lb_we     = 1'b1;
               ub_we     = 1'b1;
               bnd_waddr = '0;
               lb_wdata  = ptl_ff;
               ub_wdata  = pt_ff;
            end
            wcnt_in = wcnt_ff + 3'd1;
            if (wcnt_ff == 3'd7) begin
               l_in     = seg_base + 10'd2;
               r_in     = seg_base + 10'd5;
               k_in     = NODE_AW'(1);
               state_in = ST_K_RD;
            end
         end
         ST_K_RD: begin
            state_in = ST_K_ADD;
         end
         ST_K_ADD: begin
            ms_in  = add_q(ms_ff, {17'd0, nd_qw});
            mo_in  = add_q(mo_ff, {{16{nd_lt[31]}}, nd_lt});
            lam_in = nd_ew;
            if (k_ff == last_ff) begin
               p_in     = l_ff - 10'd3;
               state_in = ST_F_R1;
            end else begin
               p_in     = l_ff;
               up_in    = 1'b0;
               state_in = ST_C_CHK;
            end
         end
         ST_C_CHK: begin
            seg_raddr = up_ff ? (p_ff + 10'd2) : (p_ff - 10'd1);
            if (up_ff && (p_ff < l_ff)) begin
               // No upper clip: the upper pointer falls back to the lower one.
               r_in     = l_ff;
               ub_we    = 1'b1;
               ub_wdata = ptl_ff;
               k_in     = k_ff + 1'b1;
               state_in = ST_K_RD;
            end else begin
               state_in = ST_C_R2;
            end
         end
         ST_C_R2: begin
            num_in    = up_ff ? num_hi : num_lo;
            seg_raddr = up_ff ? (p_ff + 10'd1) : (p_ff - 10'd2);
            state_in  = ST_C_R3;
         end
         ST_C_R3: begin
            den_in   = slope_ms;
            state_in = ST_C_GO;
         end
         ST_C_GO: begin
            cmp_in   = seg_rd_ff;
            state_in = ST_C_WAIT;
         end
         ST_C_WAIT: begin
            if (arith_rsp.done) begin
               pt_in = arith_rsp.result;
               if (hit) begin
                  wcnt_in  = '0;
                  state_in = ST_C_WR;
               end else begin
                  p_in     = up_ff ? (p_ff - 10'd3) : (p_ff + 10'd3);
                  state_in = ST_C_CHK;
               end
            end
         end
         ST_C_WR: begin
            seg_we = 1'b1;
            if (up_ff) begin
               seg_waddr = p_ff + 10'd3 + wcnt_ext;
               case (wcnt_ff)
                  3'd0:    seg_wdata = pt_ff;
                  3'd1:    seg_wdata = neg_ms;
                  default: seg_wdata = off_hi;
               endcase
               ub_we = (wcnt_ff == 3'd0);
            end else begin
               seg_waddr = p_ff - 10'd3 - wcnt_ext;
               case (wcnt_ff)
                  3'd0:    seg_wdata = pt_ff;
                  3'd1:    seg_wdata = off_lo;
                  default: seg_wdata = neg_ms;
               endcase
               lb_we = (wcnt_ff == 3'd0);
            end
            wcnt_in = wcnt_ff + 3'd1;
            if (wcnt_ff == 3'd2) begin
               if (up_ff) begin
                  r_in     = p_ff + 10'd3;
                  k_in     = k_ff + 1'b1;
                  state_in = ST_K_RD;
               end else begin
                  l_in     = p_ff - 10'd3;
                  ptl_in   = pt_ff;
                  up_in    = 1'b1;
                  p_in     = r_ff;
                  state_in = ST_C_CHK;
               end
            end
         end
         ST_F_R1: begin
            seg_raddr = p_ff + 10'd1;
            state_in  = ST_F_R2;
         end
         ST_F_R2: begin
            den_in    = slope_ms;
            seg_raddr = p_ff + 10'd2;
            state_in  = ST_F_R3;
         end
         ST_F_R3: begin
            pt_in     = off_mo;
            num_in    = neg_q(off_mo);
            seg_raddr = p_ff + 10'd3;
            // With no crossing found the last segment is taken.
            state_in  = (p_ff >= r_ff) ? ST_F_DGO : ST_F_MGO;
         end
         ST_F_MGO: begin
            state_in = ST_F_MWAIT;
         end
         ST_F_MWAIT: begin
            if (arith_rsp.done) begin
               if (add_q(arith_rsp.result, pt_ff) > 48'sd0) begin
                  state_in = ST_F_DGO;
               end else begin
                  p_in     = p_ff + 10'd3;
                  state_in = ST_F_R1;
               end
            end
         end
         ST_F_DGO: begin
            state_in = ST_F_DWAIT;
         end
         ST_F_DWAIT: begin
            if (arith_rsp.done) begin
               sol_we    = 1'b1;
               sol_waddr = last_ff;
               sol_wdata = arith_rsp.result;
               pt_in     = arith_rsp.result;
               if (last_ff == '0) begin
                  k_in     = '0;
                  state_in = ST_O_RD;
               end else begin
                  k_in     = last_ff - 1'b1;
                  state_in = ST_B_RD;
               end
            end
         end
         ST_B_RD: begin
            state_in = ST_B_WR;
         end
         ST_B_WR: begin
            sol_we    = 1'b1;
            sol_wdata = clamp_v;
            pt_in     = clamp_v;
            if (k_ff == '0) begin
               state_in = ST_O_RD;
            end else begin
               k_in     = k_ff - 1'b1;
               state_in = ST_B_RD;
            end
         end
         ST_O_RD: begin
            state_in = ST_O_LD;
         end
         ST_O_LD: begin
            rsp_valid_in = 1'b1;
            val_in       = sat32(sol_rd_ff);
            posn_in      = 6'(k_ff);
            fin_in       = (k_ff == last_ff);
            state_in     = ST_O_WAIT;
         end
         ST_O_WAIT: begin
            if (!rsp_stall) begin
               rsp_valid_in = 1'b0;
               if (k_ff == last_ff) begin
                  pos_in   = '0;
                  state_in = ST_IDLE;
               end else begin
                  k_in     = k_ff + 1'b1;
                  state_in = ST_O_RD;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pos_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pos_ff       <= pos_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      last_ff <= last_in;
      k_ff    <= k_in;
      wcnt_ff <= wcnt_in;
      up_ff   <= up_in;
      p_ff    <= p_in;
      l_ff    <= l_in;
      r_ff    <= r_in;
      ms_ff   <= ms_in;
      mo_ff   <= mo_in;
      num_ff  <= num_in;
      den_ff  <= den_in;
      cmp_ff  <= cmp_in;
      pt_ff   <= pt_in;
      ptl_ff  <= ptl_in;
      lam_ff  <= lam_in;
      val_ff  <= val_in;
      posn_ff <= posn_in;
      fin_ff  <= fin_in;
   end

   always_ff @(posedge clock) begin
      if (nd_we) begin
         nd_mem[pos_ff] <= {req_quad_weight, req_linear_term, req_edge_weight};
      end
      nd_rd_ff <= nd_mem[k_ff];
   end

   always_ff @(posedge clock) begin
      if (seg_we) begin
         seg_mem[seg_waddr] <= seg_wdata;
      end
      seg_rd_ff <= seg_mem[seg_raddr];
   end

   always_ff @(posedge clock) begin
      if (lb_we) begin
         lb_mem[bnd_waddr] <= lb_wdata;
      end
      lb_rd_ff <= lb_mem[k_ff];
   end

   always_ff @(posedge clock) begin
      if (ub_we) begin
         ub_mem[bnd_waddr] <= ub_wdata;
      end
      ub_rd_ff <= ub_mem[k_ff];
   end

   always_ff @(posedge clock) begin
      if (sol_we) begin
         sol_mem[sol_waddr] <= sol_wdata;
      end
      sol_rd_ff <= sol_mem[k_ff];
   end

   assign req_stall          = (state_ff != ST_IDLE);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_solution_value = val_ff;
   assign rsp_node_position  = posn_ff;
   assign rsp_final_value    = fin_ff;

endmodule
